### design/quaternion_point_transform_core_assert.svh
// Assertion macros for the quaternion point transform core.
// Used by the checker module only; no other dependencies.
`ifndef QUATERNION_POINT_TRANSFORM_CORE_ASSERT_SVH
`define QUATERNION_POINT_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define QPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define QPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, always on
`define QPT_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/qpt_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the quaternion point transform core.
// No dependencies.
package qpt_pkg;

    localparam int POINT_WIDTH = 32;
    localparam int QUAT_WIDTH  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = POINT_WIDTH;

    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Z  = 3'd6;

    localparam logic [POINT_WIDTH-1:0] OUT_MAX = {1'b0, {(POINT_WIDTH-1){1'b1}}};
    localparam logic [POINT_WIDTH-1:0] OUT_MIN = {1'b1, {(POINT_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                          cmd;
        logic signed [POINT_WIDTH-1:0] point_x;
        logic signed [POINT_WIDTH-1:0] point_y;
        logic signed [POINT_WIDTH-1:0] point_z;
    } t_in_req;

    typedef struct packed {
        logic signed [POINT_WIDTH-1:0] out_x;
        logic signed [POINT_WIDTH-1:0] out_y;
        logic signed [POINT_WIDTH-1:0] out_z;
        logic                          saturated;
    } t_out_req;

endpackage

### design/quaternion_point_transform_core.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle; the six-stage pipeline (offset, first
// product set, sum, second product set, sum plus offset, clamp) advances
// as one whenever the output register is empty or being taken.
// Reset: synchronous active low; clears stage valids, quaternion to 1.0,
// position to zero.
module quaternion_point_transform_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  qpt_pkg::t_in_req                    i_in_req,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output qpt_pkg::t_out_req                   o_out_req,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qpt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qpt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import qpt_pkg::*;

    localparam int P     = POINT_WIDTH;
    localparam int Q     = QUAT_WIDTH;
    localparam int FRAC  = Q - 2;
    localparam int QW    = Q + 1;
    localparam int PW    = P + 1;
    localparam int TW    = P + 5;
    localparam int RW    = P + 8;

    function automatic logic signed [TW-1:0] mul_sh_a(
        input logic signed [QW-1:0] a,
        input logic signed [PW-1:0] b
    );
        logic signed [QW+PW-1:0] prod;
        prod = a * b;
        return TW'(prod >>> FRAC);
    endfunction

    function automatic logic signed [RW-1:0] mul_sh_b(
        input logic signed [TW-1:0] a,
        input logic signed [QW-1:0] b
    );
        logic signed [TW+QW-1:0] prod;
        prod = a * b;
        return RW'(prod >>> FRAC);
    endfunction

    logic signed [Q-1:0]  r_quat [4];
    logic signed [P-1:0]  r_pos  [3];

    logic signed [QW-1:0] w_q  [4];
    logic signed [QW-1:0] w_qc [4];
    logic signed [QW-1:0] w_a  [4];
    logic signed [QW-1:0] w_b  [4];
    logic signed [PW-1:0] w_pt [3];
    logic signed [PW-1:0] w_off[3];

    logic                 w_en;

    logic                 r0_vld, r1_vld, r2_vld, r3_vld, r4_vld, r_out_vld;
    logic                 r0_cmd, r1_cmd, r2_cmd, r3_cmd;
    logic signed [PW-1:0] r0_p [3];
    logic signed [TW-1:0] r1_m [12];
    logic signed [TW-1:0] r2_t [4];
    logic signed [RW-1:0] r3_n [12];
    logic signed [RW-1:0] r4_r [3];
    t_out_req             r_out;
    t_out_req             n_out;

    assign o_cfg_ready = 1'b1;
    assign w_en        = !r_out_vld || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat[0] <= Q'(1 << FRAC);
            r_quat[1] <= '0;
            r_quat[2] <= '0;
            r_quat[3] <= '0;
            r_pos[0]  <= '0;
            r_pos[1]  <= '0;
            r_pos[2]  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_QUAT_W: r_quat[0] <= i_cfg_data[Q-1:0];
                REG_QUAT_X: r_quat[1] <= i_cfg_data[Q-1:0];
                REG_QUAT_Y: r_quat[2] <= i_cfg_data[Q-1:0];
                REG_QUAT_Z: r_quat[3] <= i_cfg_data[Q-1:0];
                REG_POS_X:  r_pos[0]  <= i_cfg_data[P-1:0];
                REG_POS_Y:  r_pos[1]  <= i_cfg_data[P-1:0];
                REG_POS_Z:  r_pos[2]  <= i_cfg_data[P-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_q[i]  = QW'(r_quat[i]);
            w_qc[i] = (i == 0) ? w_q[i] : -w_q[i];
            w_a[i]  = r0_cmd ? w_qc[i] : w_q[i];
            w_b[i]  = r2_cmd ? w_q[i]  : w_qc[i];
        end
        w_pt[0] = PW'(i_in_req.point_x);
        w_pt[1] = PW'(i_in_req.point_y);
        w_pt[2] = PW'(i_in_req.point_z);
        for (int i = 0; i < 3; i++) begin
            w_off[i] = w_pt[i] - (i_in_req.cmd ? PW'(r_pos[i]) : PW'(0));
        end
    end

    always_comb begin
        logic signed [RW-1:0] v;
        logic                 hi;
        logic                 lo;
        logic                 sat;
        logic [P-1:0]         c [3];
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            v  = r4_r[i];
            hi = !v[RW-1] && (|v[RW-2:P-1]);
            lo = v[RW-1] && !(&v[RW-2:P-1]);
            c[i] = hi ? OUT_MAX : (lo ? OUT_MIN : v[P-1:0]);
            sat  = sat | hi | lo;
        end
        n_out.out_x     = c[0];
        n_out.out_y     = c[1];
        n_out.out_z     = c[2];
        n_out.saturated = sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld    <= 1'b0;
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld    <= i_in_valid;
            r1_vld    <= r0_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r_out_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // offset
            r0_cmd <= i_in_req.cmd;
            for (int i = 0; i < 3; i++) begin
                r0_p[i] <= w_off[i];
            end
            // first Hamilton product, terms
            r1_cmd   <= r0_cmd;
            r1_m[0]  <= mul_sh_a(w_a[1], r0_p[0]);
            r1_m[1]  <= mul_sh_a(w_a[2], r0_p[1]);
            r1_m[2]  <= mul_sh_a(w_a[3], r0_p[2]);
            r1_m[3]  <= mul_sh_a(w_a[0], r0_p[0]);
            r1_m[4]  <= mul_sh_a(w_a[2], r0_p[2]);
            r1_m[5]  <= mul_sh_a(w_a[3], r0_p[1]);
            r1_m[6]  <= mul_sh_a(w_a[0], r0_p[1]);
            r1_m[7]  <= mul_sh_a(w_a[1], r0_p[2]);
            r1_m[8]  <= mul_sh_a(w_a[3], r0_p[0]);
            r1_m[9]  <= mul_sh_a(w_a[0], r0_p[2]);
            r1_m[10] <= mul_sh_a(w_a[1], r0_p[1]);
            r1_m[11] <= mul_sh_a(w_a[2], r0_p[0]);
            // first Hamilton product, sums
            r2_cmd  <= r1_cmd;
            r2_t[0] <= -r1_m[0] - r1_m[1] - r1_m[2];
            r2_t[1] <= r1_m[3] + r1_m[4] - r1_m[5];
            r2_t[2] <= r1_m[6] - r1_m[7] + r1_m[8];
            r2_t[3] <= r1_m[9] + r1_m[10] - r1_m[11];
            // second Hamilton product, terms
            r3_cmd   <= r2_cmd;
            r3_n[0]  <= mul_sh_b(r2_t[0], w_b[1]);
            r3_n[1]  <= mul_sh_b(r2_t[1], w_b[0]);
            r3_n[2]  <= mul_sh_b(r2_t[2], w_b[3]);
            r3_n[3]  <= mul_sh_b(r2_t[3], w_b[2]);
            r3_n[4]  <= mul_sh_b(r2_t[0], w_b[2]);
            r3_n[5]  <= mul_sh_b(r2_t[1], w_b[3]);
            r3_n[6]  <= mul_sh_b(r2_t[2], w_b[0]);
            r3_n[7]  <= mul_sh_b(r2_t[3], w_b[1]);
            r3_n[8]  <= mul_sh_b(r2_t[0], w_b[3]);
            r3_n[9]  <= mul_sh_b(r2_t[1], w_b[2]);
            r3_n[10] <= mul_sh_b(r2_t[2], w_b[1]);
            r3_n[11] <= mul_sh_b(r2_t[3], w_b[0]);
            // second Hamilton product, sums plus position
            r4_r[0] <= r3_n[0] + r3_n[1] + r3_n[2] - r3_n[3]
                     + (r3_cmd ? RW'(0) : RW'(r_pos[0]));
            r4_r[1] <= r3_n[4] - r3_n[5] + r3_n[6] + r3_n[7]
                     + (r3_cmd ? RW'(0) : RW'(r_pos[1]));
            r4_r[2] <= r3_n[8] + r3_n[9] - r3_n[10] + r3_n[11]
                     + (r3_cmd ? RW'(0) : RW'(r_pos[2]));
            // clamp
            r_out <= n_out;
        end
    end

endmodule

### design/qpt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the quaternion point transform core, and its bind.
// Depends on qpt_pkg and quaternion_point_transform_core_assert.svh.
`include "quaternion_point_transform_core_assert.svh"
module qpt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input qpt_pkg::t_out_req  i_out_req
);
    import qpt_pkg::*;

    logic w_clamped;

    assign w_clamped = i_out_req.out_x == OUT_MAX || i_out_req.out_x == OUT_MIN
                    || i_out_req.out_y == OUT_MAX || i_out_req.out_y == OUT_MIN
                    || i_out_req.out_z == OUT_MAX || i_out_req.out_z == OUT_MIN;

    `QPT_ASSERT_NXT_ALL(a_reset_empty, i_clk, !i_rst_n, !i_out_valid, "valid after reset")
    `QPT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_req), "stalled request changed")
    `QPT_ASSERT_IMP(a_ready_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "not ready with empty output")
    `QPT_ASSERT_IMP(a_sat_clamped, i_clk, i_rst_n, i_out_valid && i_out_req.saturated, w_clamped, "saturated flag without clamp")

endmodule

bind quaternion_point_transform_core qpt_checker u_qpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_req   (o_out_req)
);
